FILE: rtl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
// Holds the payload, coefficient and inter-stage structs and the register map.
// No dependencies.
package bsc_pkg;

	localparam int RAW_W      = 24;  // raw conversion width
	localparam int COEF_W     = 16;  // calibration coefficient width
	localparam int NUM_COEFS  = 6;
	localparam int CFG_IDX_W  = 3;

	localparam int DT_SHIFT       = 8;   // C5 scale for dT
	localparam int TEMP_SHIFT     = 23;  // dT*C6 scale
	localparam int TEMP_BASE      = 2000;
	localparam int OFF_MUL_SHIFT  = 16;  // C2 scale
	localparam int OFF_SHIFT      = 7;   // C4*dT scale
	localparam int SENS_MUL_SHIFT = 15;  // C1 scale
	localparam int SENS_SHIFT     = 8;   // C3*dT scale
	localparam int P_SHIFT1       = 21;  // D1*SENS scale
	localparam int P_SHIFT2       = 15;  // final pressure scale
	localparam int SENS_SPLIT     = 17;  // low slice width of SENS for the partial products

	localparam int DT_W   = 25;  // signed temperature difference
	localparam int PROD_W = 42;  // signed dT * coefficient
	localparam int TEMP_W = 19;
	localparam int OFF_W  = 35;
	localparam int SENS_W = 34;
	localparam int PL_W   = 41;  // D1 * low slice of SENS, unsigned
	localparam int PH_W   = 42;  // D1 * high slice of SENS, signed
	localparam int FULL_W = 60;  // D1 * SENS
	localparam int Q_W    = 39;  // D1 * SENS scaled down
	localparam int DIFF_W = 40;
	localparam int PRES_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_C1 = 3'd0,
		CFG_C2 = 3'd1,
		CFG_C3 = 3'd2,
		CFG_C4 = 3'd3,
		CFG_C5 = 3'd4,
		CFG_C6 = 3'd5
	} bsc_cfg_idx_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} bsc_in_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_centideg;
		logic        [PRES_W-1:0] pressure_comp;
	} bsc_out_t;

	typedef struct packed {
		logic [COEF_W-1:0] c1;
		logic [COEF_W-1:0] c2;
		logic [COEF_W-1:0] c3;
		logic [COEF_W-1:0] c4;
		logic [COEF_W-1:0] c5;
		logic [COEF_W-1:0] c6;
	} bsc_coef_t;

	// Hand-off from the temperature/offset/sensitivity stages to the pressure stages
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
		logic        [RAW_W-1:0]  d1;
	} bsc_mid_t;

endpackage

FILE: rtl/bsc_front.sv
// Front pipeline: dT, the three dT products, then TEMP, OFF and SENS.
// Three register stages with per-stage valid and backpressure.
// Depends on bsc_pkg.
module bsc_front import bsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bsc_coef_t coef,
	input  logic      in_valid,
	output logic      in_ready,
	input  bsc_in_t   in_data,
	output logic      mid_valid,
	input  logic      mid_ready,
	output bsc_mid_t  mid_data
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [DT_W-1:0]   dt_c, dt_s1;
	logic        [RAW_W-1:0]  d1_s1, d1_s2, d1_s3;
	logic signed [PROD_W-1:0] p_temp_s2, p_off_s2, p_sens_s2;
	logic signed [PROD_W-1:0] p_temp_b, p_off_b, p_sens_b;
	logic signed [PROD_W-1:0] temp_div, off_div, sens_div;
	logic signed [TEMP_W-1:0] temp_c, temp_s3;
	logic signed [OFF_W-1:0]  off_c, off_s3;
	logic signed [SENS_W-1:0] sens_c, sens_s3;

	// a stage takes new data when it is empty or its successor moves
	assign rdy_s3   = !v_s3 || mid_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign dt_c = $signed({1'b0, in_data.raw_temperature})
		- $signed({1'b0, coef.c5, {DT_SHIFT{1'b0}}});

	// truncate toward zero: add 2^k-1 to negative values before the shift
	always_comb begin
		p_temp_b = p_temp_s2
			+ $signed({{(PROD_W-TEMP_SHIFT){1'b0}}, {TEMP_SHIFT{p_temp_s2[PROD_W-1]}}});
		p_off_b  = p_off_s2
			+ $signed({{(PROD_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{p_off_s2[PROD_W-1]}}});
		p_sens_b = p_sens_s2
			+ $signed({{(PROD_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{p_sens_s2[PROD_W-1]}}});
		temp_div = p_temp_b >>> TEMP_SHIFT;
		off_div  = p_off_b >>> OFF_SHIFT;
		sens_div = p_sens_b >>> SENS_SHIFT;
		temp_c   = $signed(temp_div[TEMP_W-1:0]) + $signed(TEMP_W'(TEMP_BASE));
		off_c    = $signed(off_div[OFF_W-1:0])
			+ $signed({{(OFF_W-COEF_W-OFF_MUL_SHIFT){1'b0}}, coef.c2,
				{OFF_MUL_SHIFT{1'b0}}});
		sens_c   = $signed(sens_div[SENS_W-1:0])
			+ $signed({{(SENS_W-COEF_W-SENS_MUL_SHIFT){1'b0}}, coef.c1,
				{SENS_MUL_SHIFT{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			dt_s1 <= dt_c;
			d1_s1 <= in_data.raw_pressure;
		end
		if (rdy_s2 && v_s1) begin
			p_temp_s2 <= dt_s1 * $signed({1'b0, coef.c6});
			p_off_s2  <= dt_s1 * $signed({1'b0, coef.c4});
			p_sens_s2 <= dt_s1 * $signed({1'b0, coef.c3});
			d1_s2     <= d1_s1;
		end
		if (rdy_s3 && v_s2) begin
			temp_s3 <= temp_c;
			off_s3  <= off_c;
			sens_s3 <= sens_c;
			d1_s3   <= d1_s2;
		end
	end

	assign mid_valid     = v_s3;
	assign mid_data.temp = temp_s3;
	assign mid_data.off  = off_s3;
	assign mid_data.sens = sens_s3;
	assign mid_data.d1   = d1_s3;

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (temp_s3 >= -129070) && (temp_s3 <= 133070))
		else $error("temperature outside its 19-bit range");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !mid_ready |=> v_s3 && $stable(sens_s3) && $stable(off_s3))
		else $error("stalled stage 3 lost or changed its transaction");

	a_s2_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rdy_s3 |=> v_s3)
		else $error("stage 2 transaction did not reach stage 3");

endmodule

FILE: rtl/bsc_back.sv
// Back pipeline: D1*SENS as two partial products, scaling, subtract OFF, final scale.
// Three register stages; the last one is the output register.
// Depends on bsc_pkg.
module bsc_back import bsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     mid_valid,
	output logic     mid_ready,
	input  bsc_mid_t mid_data,
	output logic     out_valid,
	input  logic     out_ready,
	output bsc_out_t out_data
);

	logic v_s4, v_s5, v_s6;
	logic rdy_s4, rdy_s5, rdy_s6;

	logic        [SENS_SPLIT-1:0]        sens_lo;
	logic signed [SENS_W-SENS_SPLIT-1:0] sens_hi;
	logic        [PL_W-1:0]              pl_s4;
	logic signed [PH_W-1:0]              ph_s4;
	logic signed [OFF_W-1:0]             off_s4, off_s5;
	logic signed [TEMP_W-1:0]            temp_s4, temp_s5;
	logic signed [FULL_W-1:0]            full_c, full_b, q_c;
	logic signed [Q_W-1:0]               q_s5;
	logic signed [DIFF_W-1:0]            diff_c, diff_b, p_c;
	bsc_out_t                            out_s6;

	assign rdy_s6    = !v_s6 || out_ready;
	assign rdy_s5    = !v_s5 || rdy_s6;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign mid_ready = rdy_s4;

	assign sens_lo = mid_data.sens[SENS_SPLIT-1:0];
	assign sens_hi = $signed(mid_data.sens[SENS_W-1:SENS_SPLIT]);

	// recombine the partial products, then scale with truncation toward zero
	always_comb begin
		full_c = $signed({{(FULL_W-PH_W-SENS_SPLIT){ph_s4[PH_W-1]}}, ph_s4,
				{SENS_SPLIT{1'b0}}})
			+ $signed({{(FULL_W-PL_W){1'b0}}, pl_s4});
		full_b = full_c
			+ $signed({{(FULL_W-P_SHIFT1){1'b0}}, {P_SHIFT1{full_c[FULL_W-1]}}});
		q_c    = full_b >>> P_SHIFT1;
		diff_c = $signed({q_s5[Q_W-1], q_s5})
			- $signed({{(DIFF_W-OFF_W){off_s5[OFF_W-1]}}, off_s5});
		diff_b = diff_c
			+ $signed({{(DIFF_W-P_SHIFT2){1'b0}}, {P_SHIFT2{diff_c[DIFF_W-1]}}});
		p_c    = diff_b >>> P_SHIFT2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= mid_valid;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && mid_valid) begin
			pl_s4   <= mid_data.d1 * sens_lo;
			ph_s4   <= $signed({1'b0, mid_data.d1}) * sens_hi;
			off_s4  <= mid_data.off;
			temp_s4 <= mid_data.temp;
		end
		if (rdy_s5 && v_s4) begin
			q_s5    <= q_c[Q_W-1:0];
			off_s5  <= off_s4;
			temp_s5 <= temp_s4;
		end
		if (rdy_s6 && v_s5) begin
			out_s6.temp_centideg <= temp_s5;
			out_s6.pressure_comp <= p_c[PRES_W-1:0];
		end
	end

	assign out_valid = v_s6;
	assign out_data  = out_s6;

	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !rdy_s5 |=> v_s5 && $stable(q_s5))
		else $error("stalled stage 5 lost or changed its transaction");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s6) |-> $past(v_s5))
		else $error("output became valid without a transaction in stage 5");

	a_s4_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && rdy_s5 |=> v_s5)
		else $error("stage 4 transaction did not reach stage 5");

endmodule

FILE: rtl/baro_sensor_compensation.sv
// Top level of the barometric sensor first-order compensation block.
// Holds the calibration coefficient registers and joins the two pipeline halves.
// Depends on bsc_pkg, bsc_front, bsc_back.

// One transaction carries a raw pressure conversion and a raw temperature conversion;
// one result transaction carries the temperature in hundredths of a degree and the
// compensated pressure (low 32 bits, wraps when negative). The datapath is six register
// stages, one transaction per clock: dT, the three dT products, TEMP/OFF/SENS, the two
// partial products of D1*SENS, the scaled product, and the output register. The block
// keeps taking inputs each cycle for as long as the result side keeps up. Backpressure
// ripples stage by stage, so empty stages still fill while the output is held. All
// divisions truncate toward zero. The six coefficients are written through cfg_we,
// cfg_idx and cfg_wdata (index 0..5 for C1..C6, other indexes ignored) and reset to
// zero; write them only while no transaction is in flight.
module baro_sensor_compensation import bsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bsc_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bsc_out_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [COEF_W-1:0]    cfg_wdata
);

	bsc_coef_t coef_q;
	logic      mid_valid;
	logic      mid_ready;
	bsc_mid_t  mid_data;

	// coefficient registers; drop writes to unmapped indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			unique case (bsc_cfg_idx_t'(cfg_idx))
				CFG_C1: begin
					coef_q.c1 <= cfg_wdata;
				end
				CFG_C2: begin
					coef_q.c2 <= cfg_wdata;
				end
				CFG_C3: begin
					coef_q.c3 <= cfg_wdata;
				end
				CFG_C4: begin
					coef_q.c4 <= cfg_wdata;
				end
				CFG_C5: begin
					coef_q.c5 <= cfg_wdata;
				end
				CFG_C6: begin
					coef_q.c6 <= cfg_wdata;
				end
				default: begin
					coef_q <= coef_q;
				end
			endcase
		end
	end

	// TEMP, OFF and SENS
	bsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid_data  (mid_data)
	);

	// pressure from D1, SENS and OFF
	bsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid_data  (mid_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// input side can only block when every stage is full and the output is held
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked while the pipeline has room");

	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_idx >= CFG_IDX_W'(NUM_COEFS)) |=> $stable(coef_q))
		else $error("write to an unmapped index changed a coefficient");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (bsc_cfg_idx_t'(cfg_idx) == CFG_C5) |=> coef_q.c5 == $past(cfg_wdata))
		else $error("reference temperature coefficient not written");

endmodule
